FILE: hw/rtl/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared widths, register indexes, sequencer codes, the control store and
// the saturating fixed-point helpers of the PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int QW         = 2 * DATA_WIDTH;
    localparam int CNT_W      = $clog2(QW);
    localparam int NUM_REGS   = 8;
    localparam int CFG_IDX_W  = $clog2(NUM_REGS);

    typedef logic signed [DATA_WIDTH-1:0] t_word;
    typedef logic        [DATA_WIDTH-1:0] t_uword_data;
    typedef logic        [QW-1:0]         t_wide;
    typedef logic        [CNT_W-1:0]      t_cnt;
    typedef logic        [CFG_IDX_W-1:0]  t_cfg_idx;

    localparam t_word    W_MAX    = t_word'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    localparam t_word    W_MIN    = t_word'({1'b1, {(DATA_WIDTH-1){1'b0}}});
    localparam t_cnt     CNT_LAST = t_cnt'(QW - 1);

    localparam t_cfg_idx REG_TARGET      = t_cfg_idx'(0);
    localparam t_cfg_idx REG_GAIN_PROP   = t_cfg_idx'(1);
    localparam t_cfg_idx REG_GAIN_INTEG  = t_cfg_idx'(2);
    localparam t_cfg_idx REG_GAIN_DERIV  = t_cfg_idx'(3);
    localparam t_cfg_idx REG_ACCUM_UPPER = t_cfg_idx'(4);
    localparam t_cfg_idx REG_ACCUM_LOWER = t_cfg_idx'(5);
    localparam t_cfg_idx REG_DRIVE_UPPER = t_cfg_idx'(6);
    localparam t_cfg_idx REG_DRIVE_LOWER = t_cfg_idx'(7);

    localparam int STEP_W = 5;
    localparam int OP_W   = 4;
    localparam int COND_W = 3;

    typedef logic [STEP_W-1:0] t_step;
    typedef logic [OP_W-1:0]   t_op;
    typedef logic [COND_W-1:0] t_cond;

    localparam t_step ST_EMIT  = t_step'(0);
    localparam t_step ST_WAIT  = t_step'(1);
    localparam t_step ST_CHK   = t_step'(2);
    localparam t_step ST_ERR   = t_step'(3);
    localparam t_step ST_MUL_P = t_step'(4);
    localparam t_step ST_SAT_P = t_step'(5);
    localparam t_step ST_MUL_I = t_step'(6);
    localparam t_step ST_SAT_I = t_step'(7);
    localparam t_step ST_MUL_T = t_step'(8);
    localparam t_step ST_ACC   = t_step'(9);
    localparam t_step ST_DELTA = t_step'(10);
    localparam t_step ST_MUL_D = t_step'(11);
    localparam t_step ST_DIV   = t_step'(12);
    localparam t_step ST_SAT_D = t_step'(13);
    localparam t_step ST_SUM   = t_step'(14);
    localparam t_step ST_CLR   = t_step'(15);
    localparam t_step ST_INV   = t_step'(16);

    localparam t_op OP_NOP   = t_op'(0);
    localparam t_op OP_EMIT  = t_op'(1);
    localparam t_op OP_ERR   = t_op'(2);
    localparam t_op OP_MUL_P = t_op'(3);
    localparam t_op OP_SAT_P = t_op'(4);
    localparam t_op OP_MUL_I = t_op'(5);
    localparam t_op OP_SAT_I = t_op'(6);
    localparam t_op OP_MUL_T = t_op'(7);
    localparam t_op OP_ACC   = t_op'(8);
    localparam t_op OP_DELTA = t_op'(9);
    localparam t_op OP_MUL_D = t_op'(10);
    localparam t_op OP_DIV   = t_op'(11);
    localparam t_op OP_SAT_D = t_op'(12);
    localparam t_op OP_SUM   = t_op'(13);
    localparam t_op OP_CLR   = t_op'(14);
    localparam t_op OP_INV   = t_op'(15);

    localparam t_cond C_NONE    = t_cond'(0);
    localparam t_cond C_ALWAYS  = t_cond'(1);
    localparam t_cond C_NOREQ   = t_cond'(2);
    localparam t_cond C_CLEAR   = t_cond'(3);
    localparam t_cond C_DTZERO  = t_cond'(4);
    localparam t_cond C_NOPRIOR = t_cond'(5);
    localparam t_cond C_DIVMORE = t_cond'(6);
    localparam t_cond C_OUTBUSY = t_cond'(7);

    typedef struct packed {
        logic  take;
        t_op   op;
        t_cond cond;
        t_step target;
    } t_ucw;

    function automatic t_ucw ucode(t_step s);
        t_ucw w;
        case (s)
            ST_EMIT:  w = '{1'b0, OP_EMIT,  C_OUTBUSY, ST_EMIT};
            ST_WAIT:  w = '{1'b1, OP_NOP,   C_NOREQ,   ST_WAIT};
            ST_CHK:   w = '{1'b0, OP_NOP,   C_CLEAR,   ST_CLR};
            ST_ERR:   w = '{1'b0, OP_ERR,   C_DTZERO,  ST_INV};
            ST_MUL_P: w = '{1'b0, OP_MUL_P, C_NONE,    ST_WAIT};
            ST_SAT_P: w = '{1'b0, OP_SAT_P, C_NONE,    ST_WAIT};
            ST_MUL_I: w = '{1'b0, OP_MUL_I, C_NONE,    ST_WAIT};
            ST_SAT_I: w = '{1'b0, OP_SAT_I, C_NONE,    ST_WAIT};
            ST_MUL_T: w = '{1'b0, OP_MUL_T, C_NONE,    ST_WAIT};
            ST_ACC:   w = '{1'b0, OP_ACC,   C_NONE,    ST_WAIT};
            ST_DELTA: w = '{1'b0, OP_DELTA, C_NOPRIOR, ST_SUM};
            ST_MUL_D: w = '{1'b0, OP_MUL_D, C_NONE,    ST_WAIT};
            ST_DIV:   w = '{1'b0, OP_DIV,   C_DIVMORE, ST_DIV};
            ST_SAT_D: w = '{1'b0, OP_SAT_D, C_NONE,    ST_WAIT};
            ST_SUM:   w = '{1'b0, OP_SUM,   C_ALWAYS,  ST_EMIT};
            ST_CLR:   w = '{1'b0, OP_CLR,   C_ALWAYS,  ST_EMIT};
            ST_INV:   w = '{1'b0, OP_INV,   C_ALWAYS,  ST_EMIT};
            default:  w = '{1'b0, OP_NOP,   C_ALWAYS,  ST_WAIT};
        endcase
        return w;
    endfunction

    function automatic t_uword_data magn(t_word v);
        t_uword_data u;
        u = t_uword_data'(v);
        return u[DATA_WIDTH-1] ? t_uword_data'(~u + 1'b1) : u;
    endfunction

    function automatic t_word sat_wide(logic [DATA_WIDTH:0] v);
        if (v[DATA_WIDTH] != v[DATA_WIDTH-1]) begin
            return v[DATA_WIDTH] ? W_MIN : W_MAX;
        end
        return t_word'(v[DATA_WIDTH-1:0]);
    endfunction

    function automatic t_word sat_add(t_word a, t_word b);
        logic [DATA_WIDTH:0] s;
        s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
        return sat_wide(s);
    endfunction

    function automatic t_word sat_sub(t_word a, t_word b);
        logic [DATA_WIDTH:0] s;
        s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
        return sat_wide(s);
    endfunction

    function automatic t_word from_sm(logic neg, t_wide mag);
        t_wide lim;
        lim = neg ? (QW'(1) << (DATA_WIDTH - 1)) : ((QW'(1) << (DATA_WIDTH - 1)) - QW'(1));
        if (mag > lim) begin
            return neg ? W_MIN : W_MAX;
        end
        return neg ? t_word'(~mag[DATA_WIDTH-1:0] + 1'b1) : t_word'(mag[DATA_WIDTH-1:0]);
    endfunction

endpackage

FILE: hw/rtl/pidc_in_if.sv
// ----------------------------------------------------------------------------
// pidc_in_if
// Request channel: command, measured value and sample interval.
// ----------------------------------------------------------------------------
interface pidc_in_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    pidc_pkg::t_word             measured;
    logic [pidc_pkg::DATA_WIDTH-1:0] interval;

    modport source (output valid, output cmd, output measured, output interval, input ready);
    modport sink   (input valid, input cmd, input measured, input interval, output ready);
endinterface

FILE: hw/rtl/pidc_out_if.sv
// ----------------------------------------------------------------------------
// pidc_out_if
// Result channel: status, error, the three terms and the drive value.
// ----------------------------------------------------------------------------
interface pidc_out_if;
    logic            valid;
    logic            ready;
    logic            status;
    pidc_pkg::t_word err_value;
    pidc_pkg::t_word prop_term;
    pidc_pkg::t_word integ_term;
    pidc_pkg::t_word deriv_term;
    pidc_pkg::t_word drive;

    modport source (output valid, output status, output err_value, output prop_term,
                    output integ_term, output deriv_term, output drive, input ready);
    modport sink   (input valid, input status, input err_value, input prop_term,
                    input integ_term, input deriv_term, input drive, output ready);
endinterface

FILE: hw/rtl/pid_with_integral_clamp.sv
// ----------------------------------------------------------------------------
// pid_with_integral_clamp
// A clear or a zero interval goes straight to the result, the first sample
// after a clear skips the derivative, and a sample with a prior error runs
// the 64-step restoring divider. The result is loaded once the output is
// free; a new request is taken in the cycle after the result is loaded.
// Reset (synchronous, active low) clears the state and restores the limits.
// ----------------------------------------------------------------------------
module pid_with_integral_clamp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    pidc_in_if.sink                    i_req,
    pidc_out_if.source                 o_rsp,
    input  logic                       i_cfg_we,
    input  pidc_pkg::t_cfg_idx         i_cfg_idx,
    input  logic [pidc_pkg::DATA_WIDTH-1:0] i_cfg_data
);

    localparam int DW = pidc_pkg::DATA_WIDTH;

    pidc_pkg::t_word  r_target, r_kp, r_ki, r_kd;
    pidc_pkg::t_word  r_acc_hi, r_acc_lo, r_drv_hi, r_drv_lo;
    pidc_pkg::t_word  r_acc, r_last_err;
    logic             r_has_prior;
    pidc_pkg::t_step  r_step, n_step;
    pidc_pkg::t_cnt   r_cnt;
    logic             r_out_valid;

    logic             r_cmd;
    pidc_pkg::t_word  r_meas;
    logic [DW-1:0]    r_dt;
    pidc_pkg::t_word  r_err, r_p, r_t, r_delta, r_d, r_y;
    pidc_pkg::t_wide  r_prod, r_quo;
    logic [DW-1:0]    r_rem;
    logic             r_neg, r_zero, r_stat;

    logic             r_o_status;
    pidc_pkg::t_word  r_o_err, r_o_p, r_o_i, r_o_d, r_o_drive;

    pidc_pkg::t_ucw   w_uw;
    logic             w_jump, w_busy, w_take;
    logic [DW-1:0]    w_ma, w_mb;
    logic             w_mneg;
    pidc_pkg::t_wide  w_prod;
    pidc_pkg::t_word  w_sm, w_acc_sum, w_acc_hi, w_acc_new, w_y0, w_y_hi, w_y_new;
    logic [DW:0]      w_trial;
    logic             w_ge;

    // sequencer
    always_comb begin
        w_uw   = pidc_pkg::ucode(r_step);
        w_busy = r_out_valid && !o_rsp.ready;
        case (w_uw.cond)
            pidc_pkg::C_NONE:    w_jump = 1'b0;
            pidc_pkg::C_ALWAYS:  w_jump = 1'b1;
            pidc_pkg::C_NOREQ:   w_jump = !i_req.valid;
            pidc_pkg::C_CLEAR:   w_jump = r_cmd;
            pidc_pkg::C_DTZERO:  w_jump = (r_dt == '0);
            pidc_pkg::C_NOPRIOR: w_jump = !r_has_prior;
            pidc_pkg::C_DIVMORE: w_jump = (r_cnt != pidc_pkg::CNT_LAST);
            pidc_pkg::C_OUTBUSY: w_jump = w_busy;
            default:             w_jump = 1'b0;
        endcase
        n_step = w_jump ? w_uw.target : pidc_pkg::t_step'(r_step + 1'b1);
    end

    assign i_req.ready = w_uw.take;
    assign w_take      = i_req.valid && w_uw.take;

    // multiplier operand selection
    always_comb begin
        w_ma   = '0;
        w_mb   = '0;
        w_mneg = 1'b0;
        case (w_uw.op)
            pidc_pkg::OP_MUL_P: begin
                w_ma   = pidc_pkg::magn(r_kp);
                w_mb   = pidc_pkg::magn(r_err);
                w_mneg = r_kp[DW-1] ^ r_err[DW-1];
            end
            pidc_pkg::OP_MUL_I: begin
                w_ma   = pidc_pkg::magn(r_ki);
                w_mb   = pidc_pkg::magn(r_err);
                w_mneg = r_ki[DW-1] ^ r_err[DW-1];
            end
            pidc_pkg::OP_MUL_T: begin
                w_ma   = pidc_pkg::magn(r_t);
                w_mb   = r_dt;
                w_mneg = r_t[DW-1];
            end
            pidc_pkg::OP_MUL_D: begin
                w_ma   = pidc_pkg::magn(r_kd);
                w_mb   = pidc_pkg::magn(r_delta);
                w_mneg = r_kd[DW-1] ^ r_delta[DW-1];
            end
            default: begin
                w_ma   = '0;
                w_mb   = '0;
                w_mneg = 1'b0;
            end
        endcase
    end

    assign w_prod = pidc_pkg::t_wide'(w_ma) * pidc_pkg::t_wide'(w_mb);

    // shared saturation of product or quotient
    assign w_sm = pidc_pkg::from_sm(r_neg, (w_uw.op == pidc_pkg::OP_SAT_D) ?
                                    r_quo : (r_prod >> pidc_pkg::FRAC_BITS));

    assign w_acc_sum = pidc_pkg::sat_add(r_acc, w_sm);
    assign w_acc_hi  = (w_acc_sum > r_acc_hi) ? r_acc_hi : w_acc_sum;
    assign w_acc_new = (w_acc_hi < r_acc_lo) ? r_acc_lo : w_acc_hi;

    assign w_y0    = pidc_pkg::sat_add(pidc_pkg::sat_add(r_p, r_acc), r_d);
    assign w_y_hi  = (w_y0 > r_drv_hi) ? r_drv_hi : w_y0;
    assign w_y_new = (w_y_hi < r_drv_lo) ? r_drv_lo : w_y_hi;

    assign w_trial = {r_rem, r_prod[pidc_pkg::QW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dt});

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= pidc_pkg::ST_WAIT;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
            r_last_err  <= '0;
            r_has_prior <= 1'b0;
            r_target    <= '0;
            r_kp        <= '0;
            r_ki        <= '0;
            r_kd        <= '0;
            r_acc_hi    <= pidc_pkg::W_MAX;
            r_acc_lo    <= pidc_pkg::W_MIN;
            r_drv_hi    <= pidc_pkg::W_MAX;
            r_drv_lo    <= pidc_pkg::W_MIN;
        end else begin
            r_step <= n_step;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pidc_pkg::REG_TARGET:      r_target <= pidc_pkg::t_word'(i_cfg_data);
                    pidc_pkg::REG_GAIN_PROP:   r_kp     <= pidc_pkg::t_word'(i_cfg_data);
                    pidc_pkg::REG_GAIN_INTEG:  r_ki     <= pidc_pkg::t_word'(i_cfg_data);
                    pidc_pkg::REG_GAIN_DERIV:  r_kd     <= pidc_pkg::t_word'(i_cfg_data);
                    pidc_pkg::REG_ACCUM_UPPER: r_acc_hi <= pidc_pkg::t_word'(i_cfg_data);
                    pidc_pkg::REG_ACCUM_LOWER: r_acc_lo <= pidc_pkg::t_word'(i_cfg_data);
                    pidc_pkg::REG_DRIVE_UPPER: r_drv_hi <= pidc_pkg::t_word'(i_cfg_data);
                    pidc_pkg::REG_DRIVE_LOWER: r_drv_lo <= pidc_pkg::t_word'(i_cfg_data);
                    default: ;
                endcase
            end
            case (w_uw.op)
                pidc_pkg::OP_ACC:   r_acc <= w_acc_new;
                pidc_pkg::OP_MUL_D: r_cnt <= '0;
                pidc_pkg::OP_DIV:   r_cnt <= pidc_pkg::t_cnt'(r_cnt + 1'b1);
                pidc_pkg::OP_SUM: begin
                    r_last_err  <= r_err;
                    r_has_prior <= 1'b1;
                end
                pidc_pkg::OP_CLR: begin
                    r_acc       <= '0;
                    r_last_err  <= '0;
                    r_has_prior <= 1'b0;
                end
                default: ;
            endcase
            if (w_uw.op == pidc_pkg::OP_EMIT && !w_busy) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd  <= i_req.cmd;
            r_meas <= i_req.measured;
            r_dt   <= i_req.interval;
        end
        case (w_uw.op)
            pidc_pkg::OP_ERR: begin
                r_err  <= pidc_pkg::sat_sub(r_target, r_meas);
                r_zero <= 1'b0;
                r_stat <= 1'b0;
            end
            pidc_pkg::OP_MUL_P, pidc_pkg::OP_MUL_I, pidc_pkg::OP_MUL_T: begin
                r_prod <= w_prod;
                r_neg  <= w_mneg;
            end
            pidc_pkg::OP_MUL_D: begin
                r_prod <= w_prod;
                r_neg  <= w_mneg;
                r_rem  <= '0;
                r_quo  <= '0;
            end
            pidc_pkg::OP_SAT_P: r_p <= w_sm;
            pidc_pkg::OP_SAT_I: r_t <= w_sm;
            pidc_pkg::OP_DELTA: begin
                r_delta <= pidc_pkg::sat_sub(r_err, r_last_err);
                r_d     <= '0;
            end
            pidc_pkg::OP_DIV: begin
                r_prod <= {r_prod[pidc_pkg::QW-2:0], 1'b0};
                r_quo  <= {r_quo[pidc_pkg::QW-2:0], w_ge};
                r_rem  <= w_ge ? DW'(w_trial - {1'b0, r_dt}) : w_trial[DW-1:0];
            end
            pidc_pkg::OP_SAT_D: r_d <= w_sm;
            pidc_pkg::OP_SUM:   r_y <= w_y_new;
            pidc_pkg::OP_CLR: begin
                r_zero <= 1'b1;
                r_stat <= 1'b0;
            end
            pidc_pkg::OP_INV: begin
                r_zero <= 1'b1;
                r_stat <= 1'b1;
            end
            default: ;
        endcase
        if (w_uw.op == pidc_pkg::OP_EMIT && !w_busy) begin
            r_o_status <= r_stat;
            r_o_err    <= r_zero ? '0 : r_err;
            r_o_p      <= r_zero ? '0 : r_p;
            r_o_i      <= r_zero ? '0 : r_acc;
            r_o_d      <= r_zero ? '0 : r_d;
            r_o_drive  <= r_zero ? '0 : r_y;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_o_status;
    assign o_rsp.err_value  = r_o_err;
    assign o_rsp.prop_term  = r_o_p;
    assign o_rsp.integ_term = r_o_i;
    assign o_rsp.deriv_term = r_o_d;
    assign o_rsp.drive      = r_o_drive;

`ifndef SYNTH
    a_take_to_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_step == pidc_pkg::ST_CHK))
        else $error("request taken but sequencer did not advance");

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == pidc_pkg::ST_DIV && r_cnt == pidc_pkg::CNT_LAST)
        |=> (r_step == pidc_pkg::ST_SAT_D))
        else $error("divider ran past its last step");

    a_clear_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == pidc_pkg::ST_CLR)
        |=> (r_acc == '0 && r_last_err == '0 && !r_has_prior))
        else $error("clear left controller state");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready)
        |=> (r_out_valid && $stable(r_o_drive) && $stable(r_o_status)))
        else $error("waiting result overwritten or dropped");
`endif

endmodule
